/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at each rising clock edge outside reset.
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Command codes, field widths and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package rau_pkg;
    localparam int WORD_BITS_DEF = 32;
    localparam int IN_BITS  = 32;
    localparam int DEN_BITS = 31;
    localparam int CMD_BITS = 4;
    localparam int ORD_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_RED = 4'd0;
    localparam logic [CMD_BITS-1:0] CMD_ADD = 4'd1;
    localparam logic [CMD_BITS-1:0] CMD_SUB = 4'd2;
    localparam logic [CMD_BITS-1:0] CMD_MUL = 4'd3;
    localparam logic [CMD_BITS-1:0] CMD_DIV = 4'd4;
    localparam logic [CMD_BITS-1:0] CMD_NEG = 4'd5;
    localparam logic [CMD_BITS-1:0] CMD_ABS = 4'd6;
    localparam logic [CMD_BITS-1:0] CMD_INV = 4'd7;
    localparam logic [CMD_BITS-1:0] CMD_CMP = 4'd8;

    localparam logic [ORD_BITS-1:0] ORD_LT = 2'd0;
    localparam logic [ORD_BITS-1:0] ORD_EQ = 2'd1;
    localparam logic [ORD_BITS-1:0] ORD_GT = 2'd2;

    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic       build;
        logic       gcd_two;
        logic       gcd_step;
        logic       div_init;
        logic       div_step;
        logic       emit;
    } t_dp_cmd;

    typedef struct packed {
        logic no_reduce;
        logic both_even;
        logic x_zero;
    } t_dp_stat;
endpackage

/* hdl/rau_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one command word with two fractions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rau_req_if import rau_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic [CMD_BITS-1:0]        command;
    logic signed [IN_BITS-1:0]  a_num;
    logic signed [IN_BITS-1:0]  a_den;
    logic signed [IN_BITS-1:0]  b_num;
    logic signed [IN_BITS-1:0]  b_den;
    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

/* hdl/rau_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface rau_rsp_if import rau_pkg::*; ;
    logic                       valid;
    logic                       ready;
    logic signed [IN_BITS-1:0]  res_num;
    logic [DEN_BITS-1:0]        res_den;
    logic [ORD_BITS-1:0]        order;
    logic                       overflow;
    modport source (output valid, res_num, res_den, order, overflow, input ready);
    modport sink   (input valid, res_num, res_den, order, overflow, output ready);
endinterface

/* hdl/rational_arithmetic_unit.sv */
// Sequence: three multiply steps, a build step, the binary gcd (one step a cycle),
// the restoring divide steps, then an emit step.
// Compare and unused commands skip gcd and divide.
// One word is in flight at a time; the gcd loop and the restoring dividers set
// the rate. The finished result waits in an output register.
// Reset (synchronous, active low) returns the controller to idle and drops valid.
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Fraction ALU with gcd reduction, overflow detection and compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rational_arithmetic_unit import rau_pkg::*; #(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    rau_ctrl #(.W(WORD_BITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    rau_datapath #(.W(WORD_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat),
        .i_command  (i_req.command),
        .i_a_num    (i_req.a_num),
        .i_a_den    (i_req.a_den),
        .i_b_num    (i_req.b_num),
        .i_b_den    (i_req.b_den),
        .o_res_num  (o_rsp.res_num),
        .o_res_den  (o_rsp.res_den),
        .o_order    (o_rsp.order),
        .o_overflow (o_rsp.overflow)
    );
endmodule

/* hdl/rau_datapath.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic datapath
// Operand unpacking, shared multiplier, binary gcd and restoring dividers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module rau_datapath import rau_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic                       i_clk,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  logic [CMD_BITS-1:0]        i_command,
    input  logic signed [IN_BITS-1:0]  i_a_num,
    input  logic signed [IN_BITS-1:0]  i_a_den,
    input  logic signed [IN_BITS-1:0]  i_b_num,
    input  logic signed [IN_BITS-1:0]  i_b_den,
    output logic signed [IN_BITS-1:0]  o_res_num,
    output logic [DEN_BITS-1:0]        o_res_den,
    output logic [ORD_BITS-1:0]        o_order,
    output logic                       o_overflow
);
    localparam int PW = 2 * W;
    localparam int KW = $clog2(PW + 1);

    function automatic logic [W-1:0] mag(input logic [W-1:0] v);
        return v[W-1] ? (~v + 1'b1) : v;
    endfunction

    logic [CMD_BITS-1:0] r_cmd;
    logic          r_a_neg, r_b_neg, n_a_neg, n_b_neg;
    logic [W-1:0]  r_a_num, r_a_den, r_b_num, r_b_den;
    logic [W-1:0]  n_a_num, n_a_den, n_b_num, n_b_den;
    logic [PW-1:0] r_m0, r_m1, r_m2;
    logic          r_neg;
    logic [PW-1:0] r_x, r_y, r_n, r_d, r_g, r_rn, r_rd;
    logic [KW-1:0] r_k;

    // Operand unpacking: low W bits, split into sign and magnitude, zero denominator taken as one.
    logic [W-1:0] an_m, ad_m, bn_m, bd_m;
    logic         ad_z, bd_z;
    always_comb begin
        an_m = mag(i_a_num[W-1:0]);
        ad_m = mag(i_a_den[W-1:0]);
        bn_m = mag(i_b_num[W-1:0]);
        bd_m = mag(i_b_den[W-1:0]);
        ad_z = (ad_m == '0);
        bd_z = (bd_m == '0);
        n_a_num = an_m;
        n_a_den = ad_z ? W'(1) : ad_m;
        n_a_neg = (an_m != '0) && (i_a_num[W-1] != (!ad_z && i_a_den[W-1]));
        n_b_num = bn_m;
        n_b_den = bd_z ? W'(1) : bd_m;
        n_b_neg = (bn_m != '0) && (i_b_num[W-1] != (!bd_z && i_b_den[W-1]));
        case (i_command)
            CMD_SUB: n_b_neg = (n_b_num != '0) && !n_b_neg;
            CMD_DIV: begin
                n_b_num = n_b_den;
                n_b_den = (bn_m == '0) ? W'(1) : bn_m;
            end
            CMD_NEG: n_a_neg = (n_a_num != '0) && !n_a_neg;
            CMD_ABS: n_a_neg = 1'b0;
            CMD_INV: begin
                n_a_num = n_a_den;
                n_a_den = (an_m == '0) ? W'(1) : an_m;
            end
            default: ;
        endcase
    end

    logic add_cls, mul_cls, unary_cls;
    always_comb begin
        add_cls   = r_cmd inside {CMD_ADD, CMD_SUB, CMD_CMP};
        mul_cls   = r_cmd inside {CMD_MUL, CMD_DIV};
        unary_cls = r_cmd inside {CMD_RED, CMD_NEG, CMD_ABS, CMD_INV};
    end

    // One shared multiplier; the cross products are formed one after another.
    logic [W-1:0]  mx, my;
    logic [PW-1:0] prod;
    always_comb begin
        mx = r_a_den;
        my = r_b_den;
        case (i_cmd.mul_sel)
            2'd0: begin
                mx = r_a_num;
                my = mul_cls ? r_b_num : r_b_den;
            end
            2'd1: begin
                mx = add_cls ? r_b_num : r_a_den;
                my = add_cls ? r_a_den : r_b_den;
            end
            default: ;
        endcase
        prod = PW'(mx) * PW'(my);
    end

    logic          sum_neg;
    logic [PW-1:0] sum_mag;
    always_comb begin
        if (r_a_neg == r_b_neg) begin
            sum_mag = r_m0 + r_m1;
            sum_neg = r_a_neg;
        end else if (r_m0 >= r_m1) begin
            sum_mag = r_m0 - r_m1;
            sum_neg = r_a_neg;
        end else begin
            sum_mag = r_m1 - r_m0;
            sum_neg = r_b_neg;
        end
    end

    // Restoring division step for numerator and denominator side by side.
    logic [PW:0] rem_n, rem_d;
    logic        q_n, q_d;
    always_comb begin
        rem_n = {r_rn, r_n[PW-1]};
        rem_d = {r_rd, r_d[PW-1]};
        q_n   = (rem_n >= {1'b0, r_g});
        q_d   = (rem_d >= {1'b0, r_g});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_command;
            r_a_neg <= n_a_neg;
            r_a_num <= n_a_num;
            r_a_den <= n_a_den;
            r_b_neg <= n_b_neg;
            r_b_num <= n_b_num;
            r_b_den <= n_b_den;
        end
        if (i_cmd.mul_en) begin
            case (i_cmd.mul_sel)
                2'd0:    r_m0 <= prod;
                2'd1:    r_m1 <= prod;
                default: r_m2 <= prod;
            endcase
        end
        if (i_cmd.build) begin
            r_k <= '0;
            if (unary_cls) begin
                r_x   <= PW'(r_a_num);
                r_y   <= PW'(r_a_den);
                r_neg <= r_a_neg;
            end else if (add_cls) begin
                r_x   <= sum_mag;
                r_y   <= r_m2;
                r_neg <= sum_neg;
            end else begin
                r_x   <= r_m0;
                r_y   <= r_m1;
                r_neg <= r_a_neg ^ r_b_neg;
            end
            r_n <= unary_cls ? PW'(r_a_num) : (add_cls ? sum_mag : r_m0);
            r_d <= unary_cls ? PW'(r_a_den) : (add_cls ? r_m2 : r_m1);
        end
        if (i_cmd.gcd_two) begin
            r_x <= r_x >> 1;
            r_y <= r_y >> 1;
            r_k <= r_k + 1'b1;
        end
        if (i_cmd.gcd_step) begin
            if (!r_x[0]) begin
                r_x <= r_x >> 1;
            end else if (!r_y[0]) begin
                r_y <= r_y >> 1;
            end else if (r_x >= r_y) begin
                r_x <= (r_x - r_y) >> 1;
            end else begin
                r_y <= (r_y - r_x) >> 1;
            end
        end
        if (i_cmd.div_init) begin
            r_g  <= r_y << r_k;
            r_rn <= '0;
            r_rd <= '0;
        end
        if (i_cmd.div_step) begin
            r_rn <= q_n ? PW'(rem_n - {1'b0, r_g}) : rem_n[PW-1:0];
            r_rd <= q_d ? PW'(rem_d - {1'b0, r_g}) : rem_d[PW-1:0];
            r_n  <= {r_n[PW-2:0], q_n};
            r_d  <= {r_d[PW-2:0], q_d};
        end
    end

    // Result formatting; r_n and r_d hold the quotients after division.
    logic          fin_neg, bad;
    logic [W-1:0]  num_w;
    logic [ORD_BITS-1:0] ord;
    always_comb begin
        fin_neg = r_neg && (r_n != '0);
        bad = (r_d[PW-1:W-1] != '0) ||
              (fin_neg ? ((r_n[PW-1:W-1] != '0) && (r_n != (PW'(1) << (W - 1))))
                       : (r_n[PW-1:W-1] != '0));
        num_w = fin_neg ? (~r_n[W-1:0] + 1'b1) : r_n[W-1:0];
        if (r_a_neg != r_b_neg) begin
            ord = r_a_neg ? ORD_LT : ORD_GT;
        end else if (r_m0 == r_m1) begin
            ord = ORD_EQ;
        end else if ((r_m0 < r_m1) != r_a_neg) begin
            ord = ORD_LT;
        end else begin
            ord = ORD_GT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (o_stat.no_reduce || bad) begin
                o_res_num  <= '0;
                o_res_den  <= DEN_BITS'(1);
                o_overflow <= !o_stat.no_reduce;
            end else begin
                o_res_num  <= IN_BITS'(signed'(num_w));
                o_res_den  <= DEN_BITS'(r_d[W-2:0]);
                o_overflow <= 1'b0;
            end
            o_order <= (r_cmd == CMD_CMP) ? ord : ORD_LT;
        end
    end

    always_comb begin
        o_stat.no_reduce = !(add_cls || mul_cls || unary_cls) || (r_cmd == CMD_CMP);
        o_stat.both_even = !r_x[0] && !r_y[0];
        o_stat.x_zero    = (r_x == '0);
    end
endmodule

/* hdl/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// Rational arithmetic controller
// Sequences multiply, gcd, divide and result hand-off for one word at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rau_ctrl import rau_pkg::*; #(
    parameter int W = WORD_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    output logic     o_rsp_valid,
    input  logic     i_rsp_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);
    localparam int CW = $clog2(2 * W);
    localparam logic [CW-1:0] DIV_LAST = CW'(2 * W - 1);
    localparam logic [CW-1:0] MUL_LAST = CW'(2);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_BUILD = 3'd2;
    localparam logic [2:0] ST_GTWO  = 3'd3;
    localparam logic [2:0] ST_GRUN  = 3'd4;
    localparam logic [2:0] ST_DIV   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    logic [2:0]    r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        n_out_valid = r_out_valid && !i_rsp_ready;
        case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_MUL;
                end
            end
            ST_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = r_cnt[1:0];
                if (r_cnt == MUL_LAST) begin
                    n_state = ST_BUILD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_BUILD: begin
                o_cmd.build = 1'b1;
                n_state = i_stat.no_reduce ? ST_EMIT : ST_GTWO;
            end
            ST_GTWO: begin
                if (i_stat.both_even) begin
                    o_cmd.gcd_two = 1'b1;
                end else begin
                    n_state = ST_GRUN;
                end
            end
            ST_GRUN: begin
                if (i_stat.x_zero) begin
                    o_cmd.div_init = 1'b1;
                    n_cnt   = '0;
                    n_state = ST_DIV;
                end else begin
                    o_cmd.gcd_step = 1'b1;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_EMIT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || i_rsp_ready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    `RAU_ASSERT_NXT(a_accept_to_mul, i_clk, i_rst_n, i_req_valid && o_req_ready, r_state == ST_MUL)
    `RAU_ASSERT_IMP(a_emit_free, i_clk, i_rst_n, o_cmd.emit, !r_out_valid || i_rsp_ready)
    `RAU_ASSERT_NXT(a_gcd_to_div, i_clk, i_rst_n, r_state == ST_GRUN && i_stat.x_zero, r_state == ST_DIV && r_cnt == '0)
    `RAU_ASSERT_NXT(a_div_done, i_clk, i_rst_n, r_state == ST_DIV && r_cnt == DIV_LAST, r_state == ST_EMIT)
endmodule
